### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gap buffer check failed");

// Clocked assertion that is also checked through reset.
`define CHK_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gap buffer check failed");

`endif

### sv/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Types, codes and constants shared by the gap buffer text store modules.
// ----------------------------------------------------------------------------
package gbts_pkg;

   // Default storage capacity in bytes.
   localparam int CAPACITY_DEF = 1024;

   // Fixed field widths of the words.
   localparam int REQ_W  = 3;
   localparam int CHAR_W = 8;
   localparam int CNT_W  = 11;
   localparam int IDX_W  = 10;
   localparam int STAT_W = 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_BACK    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FORWARD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd3;

   // Request word.
   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [CHAR_W-1:0] char_in;
      logic [CNT_W-1:0]  move_count;
      logic [IDX_W-1:0]  read_index;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic [CNT_W-1:0]  cursor_pos;
      logic [CNT_W-1:0]  text_length;
      logic [CNT_W-1:0]  moved;
      logic [STAT_W-1:0] status;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MOVE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic load_imm;
      logic load_read;
      logic load_move;
      logic step_move;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic imm_done;
      logic is_move;
      logic rem_zero;
   } dp_stat_type;

endpackage

### sv/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Text store of CAPACITY bytes kept as a gap buffer around a cursor.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel (valid/ready) as one word: insert, delete
// before the cursor, move back, move forward, or read at a logical position.
// Each request returns exactly one word on the rsp_ channel (valid/ready) with
// the byte deleted or read, the cursor, the text length, the distance moved
// and a status.
// Insert, requests that fail and requests that carry an unknown code are
// answered from the output register alone; delete and read pass through the
// registered memory read and then the output register; a move steps through
// the copy engine, which moves one byte per cycle through the single read port
// and the single write port of the text memory.
// Inserts can be taken one per cycle while the receiver takes each result; a
// delete, read or move holds off the next request until its result is loaded.
// Reset empties the text and puts the cursor at zero; no memory clearing pass.
// The result sits in an output register; while the receiver stalls, the block
// holds that word and accepts no new request until the slot frees.
// ----------------------------------------------------------------------------
module gap_buffer_text_store #(
   parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gbts_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gbts_pkg::rsp_word_type rsp_data
);
   import gbts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Controller.
   gbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath with the text memory.
   gbts_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### sv/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl
// Controller of the gap buffer: handshakes, request sequencing, output valid.
// ----------------------------------------------------------------------------
module gbts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gbts_pkg::dp_stat_type stat,
   output gbts_pkg::dp_cmd_type  cmd
);
   import gbts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      start;
   logic      load_any;

   // The output word register is free when empty or being taken now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign start     = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && !stat.imm_done) begin
               state_in = stat.is_move ? S_MOVE : S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_MOVE: begin
            if (stat.rem_zero) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.start     = start;
      cmd.load_imm  = start && stat.imm_done;
      case (state_ff)
         S_READ: begin
            cmd.load_read = 1'b1;
         end
         S_MOVE: begin
            cmd.step_move = !stat.rem_zero;
            cmd.load_move = stat.rem_zero;
         end
         default: begin
         end
      endcase
   end

   // Output valid: set on any load, cleared when the word is taken.
   assign load_any = cmd.load_imm || cmd.load_read || cmd.load_move;

   always_comb begin
      if (load_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/gbts_datapath.sv
// ----------------------------------------------------------------------------
// gbts_datapath
// Gap pointers, text memory, copy engine for cursor moves, output word.
// ----------------------------------------------------------------------------
module gbts_datapath #(
   parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbts_pkg::req_word_type req_data,
   input  gbts_pkg::dp_cmd_type   cmd,
   output gbts_pkg::dp_stat_type  stat,
   output gbts_pkg::rsp_word_type rsp_data
);
   import gbts_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = (PW > CNT_W) ? PW : CNT_W;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

   // Pointer and move registers.
   logic [PW-1:0]    gs_ff, gs_in, ge_ff, ge_in;
   logic [CNT_W-1:0] rem_ff, rem_in, moved_ff, moved_in;
   logic             back_ff, back_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   rsp_word_type     rsp_ff, rsp_in;

   // Derived values.
   logic [PW-1:0]     gs_inc, gs_dec, ge_inc, ge_dec;
   logic [PW-1:0]     len_p, post_p, len_in_p;
   logic [CW-1:0]     gs_w, ge_w, len_w, cnt_w, idx_w, lim_w, moved_w, rd_log_w;
   logic [CW-1:0]     gs_in_w, len_in_w;
   logic              full, at_start, past_end, is_back, is_move;
   logic [STAT_W-1:0] st_imm;

   // Memory ports.
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [CHAR_W-1:0] ram_wr_data, ram_rd_data;

   assign gs_inc = gs_ff + 1'b1;
   assign gs_dec = gs_ff - 1'b1;
   assign ge_inc = ge_ff + 1'b1;
   assign ge_dec = ge_ff - 1'b1;
   assign post_p = CAP_P - ge_ff;
   assign len_p  = gs_ff + post_p;

   assign gs_w  = CW'(gs_ff);
   assign ge_w  = CW'(ge_ff);
   assign len_w = CW'(len_p);
   assign cnt_w = CW'(req_data.move_count);
   assign idx_w = CW'(req_data.read_index);

   assign full     = (gs_ff == ge_ff);
   assign at_start = (gs_ff == '0);
   assign past_end = (idx_w >= len_w);
   assign is_back  = (req_data.req_type == REQ_BACK);
   assign is_move  = is_back || (req_data.req_type == REQ_FORWARD);

   // A move is clamped at the start or the end of the text.
   assign lim_w   = is_back ? gs_w : CW'(post_p);
   assign moved_w = (cnt_w < lim_w) ? cnt_w : lim_w;

   // Logical position to memory address, skipping the gap.
   assign rd_log_w = (idx_w < gs_w) ? idx_w : ge_w + (idx_w - gs_w);

   // Requests that finish in the cycle they are accepted, and their status.
   always_comb begin
      stat.imm_done = 1'b0;
      stat.is_move  = is_move;
      stat.rem_zero = (rem_ff == '0);
      st_imm        = STAT_OK;
      case (req_data.req_type)
         REQ_INSERT: begin
            stat.imm_done = 1'b1;
            st_imm        = full ? STAT_FULL : STAT_OK;
         end
         REQ_DELETE: begin
            stat.imm_done = at_start;
            st_imm        = STAT_EMPTY;
         end
         REQ_READ: begin
            stat.imm_done = past_end;
            st_imm        = STAT_PAST_END;
         end
         REQ_BACK, REQ_FORWARD: begin
            stat.imm_done = 1'b0;
         end
         default: begin
            stat.imm_done = 1'b1;
         end
      endcase
   end

   // Pointer updates, read issue and copy steps.
   always_comb begin
      gs_in       = gs_ff;
      ge_in       = ge_ff;
      rem_in      = rem_ff;
      moved_in    = moved_ff;
      back_in     = back_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = gs_dec[AW-1:0];
      if (cmd.start) begin
         case (req_data.req_type)
            REQ_INSERT: begin
               if (!full) begin
                  gs_in = gs_inc;
               end
            end
            REQ_DELETE: begin
               if (!at_start) begin
                  gs_in       = gs_dec;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = gs_dec[AW-1:0];
               end
            end
            REQ_BACK, REQ_FORWARD: begin
               rem_in   = moved_w[CNT_W-1:0];
               moved_in = moved_w[CNT_W-1:0];
               back_in  = is_back;
            end
            REQ_READ: begin
               if (!past_end) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_log_w[AW-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      // One byte is read per step and written in the following cycle.
      if (cmd.step_move) begin
         rem_in     = rem_ff - 1'b1;
         wr_pend_in = 1'b1;
         ram_rd_en  = 1'b1;
         if (back_ff) begin
            ram_rd_addr = gs_dec[AW-1:0];
            wr_addr_in  = ge_dec[AW-1:0];
            gs_in       = gs_dec;
            ge_in       = ge_dec;
         end else begin
            ram_rd_addr = ge_ff[AW-1:0];
            wr_addr_in  = gs_ff[AW-1:0];
            gs_in       = gs_inc;
            ge_in       = ge_inc;
         end
      end
   end

   // Write port: a pending copy write, or an insert at the cursor.
   assign ram_wr_en   = wr_pend_ff ||
                        (cmd.start && (req_data.req_type == REQ_INSERT) && !full);
   assign ram_wr_addr = wr_pend_ff ? wr_addr_ff : gs_ff[AW-1:0];
   assign ram_wr_data = wr_pend_ff ? ram_rd_data : req_data.char_in;

   gbts_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result word, built from the pointers after the request.
   assign len_in_p = gs_in + (CAP_P - ge_in);
   assign gs_in_w  = CW'(gs_in);
   assign len_in_w = CW'(len_in_p);

   always_comb begin
      rsp_in.char_out    = cmd.load_read ? ram_rd_data : '0;
      rsp_in.cursor_pos  = gs_in_w[CNT_W-1:0];
      rsp_in.text_length = len_in_w[CNT_W-1:0];
      rsp_in.moved       = cmd.load_move ? moved_ff : '0;
      rsp_in.status      = (cmd.load_read || cmd.load_move) ? STAT_OK : st_imm;
   end

   assign rsp_data = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff      <= '0;
         ge_ff      <= CAP_P;
         wr_pend_ff <= 1'b0;
      end else begin
         gs_ff      <= gs_in;
         ge_ff      <= ge_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      moved_ff   <= moved_in;
      back_ff    <= back_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.load_imm || cmd.load_read || cmd.load_move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### sv/gbts_checker.sv
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks of the gap buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbts_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input gbts_pkg::rsp_word_type rsp_data
);
   import gbts_pkg::*;

   // A stalled result word stays valid.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // No request is taken while a result waits in the output register.
   `CHK_ASSERT(a_no_accept_full, clock, reset, rsp_valid && !rsp_ready |-> !req_ready)

   // The first cycle after reset shows no result.
   `CHK_ASSERT_NR(a_reset_empty, clock, $past(reset) && !reset |-> !rsp_valid)

   // A failed request returns no byte and no movement.
   `CHK_ASSERT(a_fail_clean, clock, reset, rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.moved == '0 && rsp_data.char_out == '0)

endmodule

bind gap_buffer_text_store gbts_checker u_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gap buffer text store.
// ----------------------------------------------------------------------------
// A queue of request words is filled by the stimulus sequence. A clocked
// driver offers each word on the req_ channel. Every accepted word is also
// applied to a private copy of the text, cursor and gap, and that copy
// predicts the response word. A clocked monitor compares each accepted
// response word field by field with the oldest prediction. The sequence
// first walks the edge cases, then runs random edits under several idling
// patterns and a long response hold-off. Last, a short random run closes
// the sequence with both sides idling.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gbts_pkg::*;

   localparam int CAP            = CAPACITY_DEF;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LIMIT_CYCLES   = 2000000;
   localparam int PHASE_ITEMS    = 110;

   // Request codes that the block answers without any change.
   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // Words waiting to be offered and responses waiting to arrive.
   req_word_type pending_edits[$];
   rsp_word_type results_due[$];
   rsp_word_type head_due;

   // Private copy of the text store used for prediction.
   logic [CHAR_W-1:0] text_copy [CAP];
   int cursor_at;
   int tail_at;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  holdoff_asked  = 0;
   int  holdoff_taken  = 0;
   int  holdoff_left   = 0;
   int  fault_count    = 0;
   logic word_bad;

   gap_buffer_text_store #(.CAPACITY(CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one edit to the private copy and return the response it should give.
   function automatic rsp_word_type apply_edit(input req_word_type rq);
      rsp_word_type r;
      int count;
      int moved;
      int tail_len;
      int idx;
      r        = '0;
      count    = int'(rq.move_count);
      idx      = int'(rq.read_index);
      moved    = 0;
      tail_len = CAP - tail_at;
      r.status = STAT_OK;
      case (rq.req_type)
         REQ_INSERT: begin
            if (cursor_at >= tail_at) begin
               r.status = STAT_FULL;
            end else begin
               text_copy[cursor_at] = rq.char_in;
               cursor_at++;
            end
         end
         REQ_DELETE: begin
            if (cursor_at == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               cursor_at--;
               r.char_out = text_copy[cursor_at];
            end
         end
         REQ_BACK: begin
            moved = (count < cursor_at) ? count : cursor_at;
            for (int k = 0; k < moved; k++) begin
               tail_at--;
               cursor_at--;
               text_copy[tail_at] = text_copy[cursor_at];
            end
         end
         REQ_FORWARD: begin
            moved = (count < tail_len) ? count : tail_len;
            for (int k = 0; k < moved; k++) begin
               text_copy[cursor_at] = text_copy[tail_at];
               cursor_at++;
               tail_at++;
            end
         end
         REQ_READ: begin
            if (idx >= cursor_at + tail_len) begin
               r.status = STAT_PAST_END;
            end else if (idx < cursor_at) begin
               r.char_out = text_copy[idx];
            end else begin
               r.char_out = text_copy[tail_at + idx - cursor_at];
            end
         end
         default: begin
         end
      endcase
      r.cursor_pos  = CNT_W'(cursor_at);
      r.text_length = CNT_W'(cursor_at + CAP - tail_at);
      r.moved       = CNT_W'(moved);
      return r;
   endfunction

   // Driver: offers queued words and predicts each one on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         cursor_at = 0;
         tail_at   = CAP;
      end else begin
         if (req_valid && req_ready) begin
            results_due.push_back(apply_edit(req_data));
         end
         if (!req_valid || req_ready) begin
            if (pending_edits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_edits.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_taken != holdoff_asked) begin
         holdoff_taken <= holdoff_asked;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: checks each accepted response word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("response word with nothing pending: %p", rsp_data);
            fault_count = fault_count + 1;
         end else begin
            head_due = results_due.pop_front();
            word_bad = 1'b0;
            if (rsp_data.char_out !== head_due.char_out) begin
               $error("char_out: expected %0d, got %0d", head_due.char_out, rsp_data.char_out);
               word_bad = 1'b1;
            end
            if (rsp_data.cursor_pos !== head_due.cursor_pos) begin
               $error("cursor_pos: expected %0d, got %0d",
                      head_due.cursor_pos, rsp_data.cursor_pos);
               word_bad = 1'b1;
            end
            if (rsp_data.text_length !== head_due.text_length) begin
               $error("text_length: expected %0d, got %0d",
                      head_due.text_length, rsp_data.text_length);
               word_bad = 1'b1;
            end
            if (rsp_data.moved !== head_due.moved) begin
               $error("moved: expected %0d, got %0d", head_due.moved, rsp_data.moved);
               word_bad = 1'b1;
            end
            if (rsp_data.status !== head_due.status) begin
               $error("status: expected %0d, got %0d", head_due.status, rsp_data.status);
               word_bad = 1'b1;
            end
            if (word_bad) begin
               fault_count = fault_count + 1;
            end
         end
      end
   end

   // Run limit.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic queue_edit(input logic [REQ_W-1:0] code, input logic [CHAR_W-1:0] ch,
                             input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx);
      req_word_type w;
      w.req_type   = code;
      w.char_in    = ch;
      w.move_count = cnt;
      w.read_index = idx;
      pending_edits.push_back(w);
   endtask

   // Random edits; the mix leans toward inserts so the text keeps growing.
   task automatic queue_random_edits(input int n);
      int pick;
      logic [REQ_W-1:0] code;
      logic [CNT_W-1:0] cnt;
      logic [IDX_W-1:0] idx;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            code = REQ_INSERT;
         end else if (pick < 55) begin
            code = REQ_DELETE;
         end else if (pick < 67) begin
            code = REQ_BACK;
         end else if (pick < 79) begin
            code = REQ_FORWARD;
         end else if (pick < 97) begin
            code = REQ_READ;
         end else begin
            code = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
         end
         pick = $urandom_range(9);
         if (pick < 6) begin
            cnt = CNT_W'($urandom_range(8));
         end else if (pick < 9) begin
            cnt = CNT_W'($urandom_range(64));
         end else begin
            cnt = CNT_W'($urandom_range(2047));
         end
         if ($urandom_range(3) != 0) begin
            idx = IDX_W'($urandom_range(200));
         end else begin
            idx = IDX_W'($urandom_range(1023));
         end
         queue_edit(code, CHAR_W'($urandom_range(255)), cnt, idx);
      end
   endtask

   // Holds the sequence until every queued word has been answered.
   task automatic wait_drained();
      while (pending_edits.size() != 0 || req_valid || results_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stimulus sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Edge cases on an empty and a short text.
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd0);
      queue_edit(REQ_DELETE, 8'h00, 11'd0, 10'd0);
      queue_edit(REQ_BACK, 8'h00, 11'd5, 10'd0);
      queue_edit(REQ_FORWARD, 8'h00, 11'd2047, 10'd0);
      queue_edit(REQ_INSERT, 8'h00, 11'd0, 10'd0);
      queue_edit(REQ_INSERT, 8'hFF, 11'd2047, 10'd1023);
      queue_edit(REQ_INSERT, 8'hA5, 11'd0, 10'd0);
      queue_edit(REQ_INSERT, 8'h5A, 11'd0, 10'd0);
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd0);
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd3);
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd1023);
      queue_edit(REQ_BACK, 8'h00, 11'd2, 10'd0);
      queue_edit(REQ_INSERT, 8'h3C, 11'd0, 10'd0);
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd2);
      queue_edit(REQ_READ, 8'h00, 11'd0, 10'd4);
      queue_edit(REQ_BACK, 8'h00, 11'd2047, 10'd0);
      queue_edit(REQ_DELETE, 8'h00, 11'd0, 10'd0);
      queue_edit(REQ_FORWARD, 8'h00, 11'd1, 10'd0);
      queue_edit(REQ_FORWARD, 8'h00, 11'd1024, 10'd0);
      queue_edit(REQ_DELETE, 8'h00, 11'd0, 10'd0);
      for (int c = int'(REQ_SPARE_LO); c <= int'(REQ_SPARE_HI); c++) begin
         queue_edit(REQ_W'(c), 8'hFF, 11'd2047, 10'd1023);
      end
      wait_drained();

      // Random edits with a long response hold-off while words keep coming.
      holdoff_asked = holdoff_asked + 1;
      queue_random_edits(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 69;
      queue_random_edits(PHASE_ITEMS);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 69;
      queue_random_edits(PHASE_ITEMS);
      wait_drained();

      send_idle_pct  = 28;
      recv_stall_pct = 28;
      queue_random_edits(PHASE_ITEMS);
      wait_drained();

      // Short closing run with both sides idling.
      send_idle_pct  = 28;
      recv_stall_pct = 28;
      queue_random_edits(40);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
